### hdl/aes_pkg.sv
// Package: AES types, S-box tables, GF helpers and shared codes.
package aes_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3 = 3'd4;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;
  localparam logic [1:0] KEY_256 = 2'd2;
  localparam logic [1:0] KEY_RSVD = 2'd3;  // unused code, handled as a 256-bit key

  localparam logic [7:0] RCON_FIRST = 8'h01;

  // Controller to datapath commands
  typedef struct packed {
    logic ks_start;   // reset word counter and round constant
    logic ks_step;    // compute and store one schedule word
    logic blk_load;   // capture input block
    logic rk_fetch;   // issue round key read
    logic rnd_first;  // apply initial key add
    logic rnd_step;   // apply one full round
    logic rnd_last;   // apply final round
    logic out_load;   // move state into output register
  } aes_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ks_done;     // last schedule word being written
    logic [3:0] nr;    // number of rounds for current key size
  } aes_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

### hdl/aes_ctrl.sv
// Controller: sequences key expansion, the rounds of one block and the output hand-off.
module aes_ctrl
  import aes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_busy,
  input  aes_sts_t   sts,
  output aes_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_FETCH = 6'b000100,
    S_FIRST = 6'b001000,
    S_ROUND = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic       sched_ok;
  logic [3:0] rnd, rnd_next;

  // Accept a block only when idle with a valid schedule and no key register write
  assign in_ready = (state == S_IDLE) && sched_ok && !cfg_write;

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (!sched_ok && !cfg_write) begin
          cmd.ks_start = 1'b1;
          state_next = S_KEY;
        end else if (in_valid && in_ready) begin
          cmd.blk_load = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_KEY: begin
        cmd.ks_step = 1'b1;
        if (sts.ks_done) state_next = S_IDLE;
      end
      // First round key read, once the direction is known
      S_FETCH: begin
        cmd.rk_fetch = 1'b1;
        state_next = S_FIRST;
      end
      S_FIRST: begin
        cmd.rnd_first = 1'b1;
        cmd.rk_fetch = 1'b1;
        rnd_next = 4'd1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (rnd == sts.nr) begin
          cmd.rnd_last = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rnd_step = 1'b1;
          cmd.rk_fetch = 1'b1;
          rnd_next = rnd + 4'd1;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sched_ok <= 1'b0;
      rnd <= '0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      if (cfg_write) sched_ok <= 1'b0;
      else if (state == S_KEY && sts.ks_done) sched_ok <= 1'b1;
    end
  end

  // Blocks are taken only after expansion has finished
  assert property (@(posedge clk) disable iff (rst) cmd.blk_load |-> sched_ok)
    else $error("block accepted with stale schedule");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_KEY) |-> !in_ready)
    else $error("ready during key expansion");
  assert property (@(posedge clk) disable iff (rst)
    cmd.rnd_last |-> (rnd == sts.nr))
    else $error("final round at wrong count");

endmodule

### hdl/aes_dp.sv
// Datapath: key schedule memory and generator, round logic, state register.
module aes_dp
  import aes_pkg::*;
#(
  parameter int unsigned RkDepth = 60
) (
  input  logic         clk,
  input  logic         rst,
  input  aes_cmd_t     cmd,
  output aes_sts_t     sts,
  input  logic [1:0]   key_size,
  input  logic [255:0] key,
  input  logic         func_in,
  input  logic [127:0] block_in,
  output logic [127:0] state_out
);

  localparam int unsigned RkRows = (RkDepth + 3) / 4;  // one row holds one round key
  localparam int unsigned RowAW = $clog2(RkRows);
  localparam int unsigned RW = 6; // round-key word counter, holds up to 60

  logic [127:0] rk_mem [RkRows];
  logic [127:0] rk_q;      // registered round key (four words)
  logic [127:0] st;
  logic        fn;
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [RW-1:0] wi;        // schedule word being built
  logic [2:0]  kcnt;       // i mod nk
  logic [7:0]  rcon;
  logic [255:0] win;       // last eight words, newest in low bits
  logic [3:0]  rk_rnd;     // round key index for next fetch
  logic [31:0] t_w, sub_in, sub_out, new_w, old_w;

  always_comb begin
    case (key_size)
      KEY_128: nk = 4'd4;
      KEY_192: nk = 4'd6;
      default: nk = 4'd8;
    endcase
  end
  assign total = 6'(4 * (nk + 4'd7));
  assign sts.nr = nk + 4'd6;
  assign sts.ks_done = cmd.ks_step && (wi == total - 6'd1);

  // Key expansion: one word per cycle from a window of the previous nk words
  assign t_w = win[31:0];
  always_comb begin
    old_w = win[32*7 +: 32];
    case (key_size)
      KEY_128: old_w = win[32*3 +: 32];
      KEY_192: old_w = win[32*5 +: 32];
      default: old_w = win[32*7 +: 32];
    endcase
    sub_in = (kcnt == 3'd0) ? {t_w[23:0], t_w[31:24]} : t_w;
    for (int b = 0; b < 4; b++) sub_out[8*b +: 8] = SBOX[sub_in[8*b +: 8]];
    if (wi < 6'(nk)) new_w = key[255 - 32*wi[2:0] -: 32];
    else if (kcnt == 3'd0) new_w = old_w ^ sub_out ^ {rcon, 24'd0};
    else if (nk == 4'd8 && kcnt == 3'd4) new_w = old_w ^ sub_out;
    else new_w = old_w ^ t_w;
  end

  always_ff @(posedge clk) begin
    if (cmd.ks_start) begin
      wi <= '0;
      kcnt <= '0;
      rcon <= RCON_FIRST;
    end else if (cmd.ks_step) begin
      wi <= wi + 6'd1;
      win <= {win[223:0], new_w};
      if (wi < 6'(nk)) kcnt <= (kcnt == 3'(nk - 4'd1)) ? 3'd0 : kcnt + 3'd1;
      else begin
        kcnt <= (kcnt == 3'(nk - 4'd1)) ? 3'd0 : kcnt + 3'd1;
        if (kcnt == 3'd0) rcon <= xt(rcon);
      end
      if (32'(wi) < RkDepth) rk_mem[wi[2 +: RowAW]][127 - 32*wi[1:0] -: 32] <= new_w;
    end
  end

  // Round key fetch: one row per round; words beyond the store read as zero
  always_ff @(posedge clk) begin
    if (cmd.rk_fetch) begin
      for (int c = 0; c < 4; c++) begin
        if (32'(4*rk_rnd + c) < RkDepth)
          rk_q[127 - 32*c -: 32] <= rk_mem[RowAW'(rk_rnd)][127 - 32*c -: 32];
        else
          rk_q[127 - 32*c -: 32] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rk_rnd <= '0;
    else if (cmd.blk_load) rk_rnd <= func_in ? sts.nr : 4'd0;
    else if (cmd.rk_fetch) rk_rnd <= fn ? rk_rnd - 4'd1 : rk_rnd + 4'd1;
  end

  // One cipher round
  logic [127:0] ss, mx, rnd_out;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] v;
        v = fn ? st[127 - 8*(4*((c + 4 - r) % 4) + r) -: 8]
               : st[127 - 8*(4*((c + r) % 4) + r) -: 8];
        ss[127 - 8*(4*c + r) -: 8] = fn ? ISBOX[v] : SBOX[v];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, src0, src1, src2, src3;
        src0 = fn ? (ss[127 - 8*(4*c+0) -: 8] ^ rk_q[127 - 8*(4*c+0) -: 8])
                  : ss[127 - 8*(4*c+0) -: 8];
        src1 = fn ? (ss[127 - 8*(4*c+1) -: 8] ^ rk_q[127 - 8*(4*c+1) -: 8])
                  : ss[127 - 8*(4*c+1) -: 8];
        src2 = fn ? (ss[127 - 8*(4*c+2) -: 8] ^ rk_q[127 - 8*(4*c+2) -: 8])
                  : ss[127 - 8*(4*c+2) -: 8];
        src3 = fn ? (ss[127 - 8*(4*c+3) -: 8] ^ rk_q[127 - 8*(4*c+3) -: 8])
                  : ss[127 - 8*(4*c+3) -: 8];
        a0 = (r == 0) ? src0 : (r == 1) ? src1 : (r == 2) ? src2 : src3;
        a1 = (r == 0) ? src1 : (r == 1) ? src2 : (r == 2) ? src3 : src0;
        a2 = (r == 0) ? src2 : (r == 1) ? src3 : (r == 2) ? src0 : src1;
        a3 = (r == 0) ? src3 : (r == 1) ? src0 : (r == 2) ? src1 : src2;
        mx[127 - 8*(4*c + r) -: 8] = fn
          ? (gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9))
          : (gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3);
      end
    end
    rnd_out = fn ? mx : (mx ^ rk_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      st <= block_in;
      fn <= func_in;
    end else if (cmd.rnd_first) st <= st ^ rk_q;
    else if (cmd.rnd_step) st <= rnd_out;
    else if (cmd.rnd_last) st <= ss ^ rk_q;
  end

  assign state_out = st;

endmodule

### hdl/aes_block_cipher.sv
// Top level: configuration registers, input and output stream stages.
// An input transfer passes through S_FETCH, S_FIRST, the Nr rounds in S_ROUND and S_DONE (Nr = 10, 12, 14).
// The single shared round unit takes a new block only once the last result is in the output register.
// After reset or a write to the key or key-size registers, key expansion issues a start command, then
// builds 4*(Nr+1) schedule words (44, 52 or 60), one per cycle, before the next block.
// Reset: synchronous, clears the key to zero with a 128-bit key size.
module aes_block_cipher
  import aes_pkg::*;
#(
  parameter int unsigned ROUND_KEY_DEPTH = 60
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [127:0]          s_tdata,   // block_hi [63:0], block_lo [127:64]
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [127:0]          m_tdata    // result_hi [63:0], result_lo [127:64]
);

  logic [1:0]   key_size;
  logic [255:0] key;
  logic         cfg_hit;
  aes_cmd_t     cmd;
  aes_sts_t     sts;
  logic [127:0] st;

  // Configuration registers
  assign cfg_hit = cfg_we && (cfg_index <= REG_KEY_W3);
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KEY_128;
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_SIZE: key_size <= cfg_data[1:0];
        REG_KEY_W0:   key[255:192] <= cfg_data;
        REG_KEY_W1:   key[191:128] <= cfg_data;
        REG_KEY_W2:   key[127:64] <= cfg_data;
        REG_KEY_W3:   key[63:0] <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_write(cfg_hit),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_busy(m_tvalid && !m_tready), .sts(sts), .cmd(cmd)
  );

  aes_dp #(.RkDepth(ROUND_KEY_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .key_size(key_size), .key(key), .func_in(s_tuser),
    .block_in({s_tdata[63:0], s_tdata[127:64]}), .state_out(st)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {st[63:0], st[127:64]};
  end

endmodule

### test/testbench.sv
// Testbench for aes_block_cipher: known-answer rows, then random keys and blocks.
module testbench;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [127:0]          s_tdata;   // block_hi [63:0], block_lo [127:64]
  logic                  s_tuser;   // func
  logic                  m_tvalid;
  logic                  m_tready;
  logic [127:0]          m_tdata;   // result_hi [63:0], result_lo [127:64]

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct {
    int          kset;      // key setting to load first, -1 keeps the current one
    logic        func;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          known;     // expected value typed in
    logic [63:0] ehi;
    logic [63:0] elo;
  } row_t;

  aes_block_cipher u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow of the key registers and the expanded schedule
  logic [1:0]  key_size_sh;
  logic [63:0] key_sh [4];
  logic [31:0] sched [60];
  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];

  block_t      results_due [$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          stall_cnt = 0;

  // Known key settings used by the directed rows
  logic [1:0]  kset_size [9];
  logic [63:0] kset_word [9][4];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = gf_mul(r, a);
    return r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  function automatic int key_len_words();
    return (key_size_sh == KEY_128) ? 4 : ((key_size_sh == KEY_192) ? 6 : 8);
  endfunction

  // Rebuild the round-key schedule from the shadow key
  function automatic void build_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_len_words();
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_sh[(i >> 1) & 3][31:0] : key_sh[(i >> 1) & 3][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endfunction

  function automatic logic [127:0] add_round(input logic [127:0] v, input int r);
    for (int c = 0; c < 4; c++) v[127-32*c -: 32] ^= sched[4*r+c];
    return v;
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] v, input bit inv);
    logic [127:0] o;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        o[127-8*(4*c+r) -: 8] = inv ? inv_sub[v[127-8*(4*src+r) -: 8]]
                                    : fwd_sub[v[127-8*(4*src+r) -: 8]];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] v, input bit inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] acc;
    logic [127:0] o;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = v[127-8*(4*c+k) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(a[k], m[(k + 4 - r) & 3]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return o;
  endfunction

  // Expected cipher output of one block under the shadow schedule
  function automatic block_t aes_predict(input logic func, input logic [63:0] hi,
                                         input logic [63:0] lo);
    logic [127:0] v;
    int nr;
    block_t b;
    nr = key_len_words() + 6;
    v = {hi, lo};
    if (func == FUNC_ENC) begin
      v = add_round(v, 0);
      for (int r = 1; r < nr; r++) v = add_round(mix_cols(sub_shift(v, 0), 0), r);
      v = add_round(sub_shift(v, 0), nr);
    end else begin
      v = add_round(v, nr);
      for (int r = nr - 1; r >= 1; r--) v = mix_cols(add_round(sub_shift(v, 1), r), 1);
      v = add_round(sub_shift(v, 1), 0);
    end
    b.hi = v[127:64];
    b.lo = v[63:0];
    return b;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Load a key setting while the block is idle; includes a write to an unused index
  task automatic load_key(input logic [1:0] ks, input logic [63:0] w0, input logic [63:0] w1,
                          input logic [63:0] w2, input logic [63:0] w3);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write(REG_KEY_SIZE, {62'h0, ks});
    cfg_write(REG_KEY_W0, w0);
    cfg_write(REG_KEY_W1, w1);
    cfg_write(REG_KEY_W2, w2);
    cfg_write(REG_KEY_W3, w3);
    cfg_write(CFG_IDX_W'($urandom_range(5, 7)), {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
    key_size_sh = ks;
    key_sh = '{w0, w1, w2, w3};
    build_schedule();
  endtask

  // One input transfer, with an optional idle burst ahead of it
  task automatic send_block(input logic func, input logic [63:0] hi, input logic [63:0] lo,
                            input block_t due);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {lo, hi};
    s_tuser <= func;
    do @(posedge clk); while (!s_tready);
    results_due.push_back(due);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Output side backpressure in bursts
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      m_tready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      m_tready <= 1'b1;
      if (idle_on && !rst && $urandom_range(0, 7) == 0) stall_cnt <= $urandom_range(1, 16);
    end
  end

  // Result checker
  always @(posedge clk) begin
    block_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = results_due.pop_front();
        if (m_tdata[63:0] !== e.hi) begin
          $display("%0t: result_hi expected %h actual %h", $time, e.hi, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[127:64] !== e.lo) begin
          $display("%0t: result_lo expected %h actual %h", $time, e.lo, m_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    block_t due;
    int cur_kset;
    int wait_cnt;
    logic f;
    logic [63:0] h, l;
    logic [63:0] ones;
    ones = '1;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_ENC;
    m_tready = 1'b0;

    for (int i = 0; i < 256; i++) begin
      fwd_sub[i] = gf_inv(i[7:0]);
      fwd_sub[i] = fwd_sub[i] ^ rol8(fwd_sub[i], 1) ^ rol8(fwd_sub[i], 2) ^
                   rol8(fwd_sub[i], 3) ^ rol8(fwd_sub[i], 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) inv_sub[fwd_sub[i]] = i[7:0];

    // Reset key: all zero, 128-bit
    key_size_sh = KEY_128;
    key_sh = '{64'h0, 64'h0, 64'h0, 64'h0};
    build_schedule();

    kset_size = '{KEY_128, KEY_128, KEY_192, KEY_192, KEY_256, KEY_RSVD, KEY_256, KEY_256,
                  KEY_128};
    for (int k = 0; k < 9; k++)
      kset_word[k] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                       64'h1011121314151617, 64'h18191a1b1c1d1e1f};
    kset_word[1][2] = ones;  // unused words of a 128-bit key
    kset_word[1][3] = ones;
    kset_word[3][3] = ones;  // unused word of a 192-bit key
    kset_word[6] = '{ones, ones, ones, ones};
    kset_word[7] = '{64'h0, 64'h0, 64'h0, 64'h0};
    kset_word[8] = '{ones, ones, 64'h0, 64'h0};

    // Directed rows
    rows = '{
      '{-1, FUNC_ENC, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{-1, FUNC_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0},
      '{-1, FUNC_ENC, ones, ones, 0, 0, 0},
      '{-1, FUNC_DEC, ones, ones, 0, 0, 0},
      '{0, FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{-1, FUNC_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{-1, FUNC_ENC, 64'h0, 64'h0, 0, 0, 0},
      '{1, FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{2, FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
      '{-1, FUNC_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{3, FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
      '{4, FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'h8ea2b7ca516745bf, 64'heafc49904b496089},
      '{-1, FUNC_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{5, FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        64'h8ea2b7ca516745bf, 64'heafc49904b496089},
      '{-1, FUNC_DEC, ones, 64'h0, 0, 0, 0},
      '{6, FUNC_ENC, ones, ones, 0, 0, 0},
      '{-1, FUNC_DEC, ones, ones, 0, 0, 0},
      '{7, FUNC_ENC, 64'h0, 64'h0, 0, 0, 0},
      '{-1, FUNC_DEC, 64'h0, ones, 0, 0, 0},
      '{8, FUNC_ENC, ones, ones, 0, 0, 0},
      '{-1, FUNC_DEC, 64'h0, 64'h0, 0, 0, 0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_kset = -1;
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.kset >= 0 && rw.kset != cur_kset) begin
        cur_kset = rw.kset;
        load_key(kset_size[cur_kset], kset_word[cur_kset][0], kset_word[cur_kset][1],
                 kset_word[cur_kset][2], kset_word[cur_kset][3]);
      end
      if (rw.known) begin
        due.hi = rw.ehi;
        due.lo = rw.elo;
      end else begin
        due = aes_predict(rw.func, rw.hi, rw.lo);
      end
      send_block(rw.func, rw.hi, rw.lo, due);
    end

    // Random phases, each with a fresh key; the last one runs without idling
    for (int ph = 0; ph < 12; ph++) begin
      load_key(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(), rand_word());
      if (ph == 11) idle_on = 1'b0;
      for (int n = 0; n < 140; n++) begin
        f = 1'($urandom_range(0, 1));
        h = rand_word();
        l = rand_word();
        send_block(f, h, l, aes_predict(f, h, l));
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    wait_cnt = 0;
    while (results_due.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
